@@ rtl/sfr_pkg.sv @@
// Shared types, codes and CRC update functions for the serial frame receiver.
// No dependencies; used by every module in rtl/.
`default_nettype none

package sfr_pkg;

   localparam logic [15:0] SIGNATURE_RESET = 16'hDEAD;
   localparam logic [7:0]  ACK_MASK_RESET  = 8'h01;

   localparam logic [0:0] CSR_SIGNATURE = 1'b0;
   localparam logic [0:0] CSR_ACK_MASK  = 1'b1;

   localparam logic [1:0] KIND_BODY     = 2'd0;
   localparam logic [1:0] KIND_ACK_RX   = 2'd1;
   localparam logic [1:0] KIND_ACK_TX   = 2'd2;
   localparam logic [1:0] KIND_HDR_ERR  = 2'd3;

   localparam logic [7:0]  CRC8_POLY    = 8'hB2;
   localparam logic [7:0]  CRC8_XOROUT  = 8'hEA;
   localparam logic [15:0] CRC16_POLY   = 16'h8408;

   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
      logic       last;
      logic       body_ok;
   } result_type;

   typedef struct packed {
      logic [15:0] signature;
      logic [7:0]  ack_mask;
   } cfg_type;

   // lsb-first CRC8, output xored per byte
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
      end
      return c ^ CRC8_XOROUT;
   endfunction

   // CRC-16/KERMIT, reflected
   function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ rtl/sfr_in_reg.sv @@
// Input register of the serial frame receiver: captures one request per cycle while req_stall is low.
// Depends on sfr_pkg.
`default_nettype none

module sfr_in_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_mode,
   input  wire logic [7:0]        req_rx_byte,
   input  wire logic              advance,
   output logic                   item_valid,
   output sfr_pkg::item_type      item
);

   logic              valid_ff;
   sfr_pkg::item_type item_ff;

   // hold while the held request cannot move on
   assign req_stall  = valid_ff && !advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         item_ff.mode    <= req_mode;
         item_ff.rx_byte <= req_rx_byte;
      end
   end

endmodule

`default_nettype wire

@@ rtl/sfr_parser.sv @@
// Frame parser: signature hunt, header CRC8, ack handling, body CRC16, result register.
// Depends on sfr_pkg.
`default_nettype none

module sfr_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sfr_pkg::cfg_type    cfg,
   input  wire logic                item_valid,
   input  wire sfr_pkg::item_type   item,
   output logic                     advance,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output sfr_pkg::result_type      rsp
);

   localparam logic [2:0] PH_HUNT0  = 3'd0;
   localparam logic [2:0] PH_HUNT1  = 3'd1;
   localparam logic [2:0] PH_HEADER = 3'd2;
   localparam logic [2:0] PH_TRAIL  = 3'd3;
   localparam logic [2:0] PH_BODY   = 3'd4;

   logic [2:0]  phase_ff,      phase_in;
   logic [7:0]  prev_ff,       prev_in;
   logic [16:0] index_ff,      index_in;
   logic [16:0] total_ff,      total_in;
   logic [7:0]  flags_ff,      flags_in;
   logic [7:0]  hcrc_ff,       hcrc_in;
   logic [15:0] bcrc_ff,       bcrc_in;
   logic [15:0] rcrc_ff,       rcrc_in;
   logic [1:0]  txseq_ff,      txseq_in;
   logic        rsp_valid_ff;
   sfr_pkg::result_type rsp_ff, rsp_in;
   logic        emit;
   logic        fire;
   logic [16:0] index_inc;
   logic [7:0]  b;
   logic [1:0]  ack_id;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = item_valid && advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign b         = item.rx_byte;
   assign index_inc = index_ff + 17'd1;
   assign ack_id    = flags_ff[5:4];

   always_comb begin
      phase_in = phase_ff;
      prev_in  = prev_ff;
      index_in = index_ff;
      total_in = total_ff;
      flags_in = flags_ff;
      hcrc_in  = hcrc_ff;
      bcrc_in  = bcrc_ff;
      rcrc_in  = rcrc_ff;
      txseq_in = txseq_ff;
      emit     = 1'b0;
      rsp_in   = '0;
      if (item.mode) begin
         txseq_in = 2'd0;
      end else begin
         case (phase_ff)
            PH_HUNT1: begin
               if ({prev_ff, b} == cfg.signature) begin
                  phase_in = PH_HEADER;
                  index_in = 17'd2;
                  hcrc_in  = 8'h00;
                  total_in = 17'd0;
               end else begin
                  prev_in = b;
               end
            end
            PH_HEADER: begin
               if (index_ff == 17'd6) begin
                  index_in = 17'd7;
                  phase_in = (total_ff > 17'd7) ? PH_TRAIL : PH_HUNT0;
                  if (b != hcrc_ff) begin
                     phase_in    = PH_HUNT0;
                     emit        = 1'b1;
                     rsp_in.kind = sfr_pkg::KIND_HDR_ERR;
                  end else if ((flags_ff & cfg.ack_mask) != 8'h00) begin
                     if (ack_id == txseq_ff) begin
                        txseq_in     = txseq_ff + 2'd1;
                        emit         = 1'b1;
                        rsp_in.kind  = sfr_pkg::KIND_ACK_RX;
                        rsp_in.value = {6'd0, ack_id};
                     end
                  end else begin
                     emit         = 1'b1;
                     rsp_in.kind  = sfr_pkg::KIND_ACK_TX;
                     rsp_in.value = {6'd0, flags_ff[3:2]};
                  end
               end else begin
                  hcrc_in  = sfr_pkg::crc8_update(hcrc_ff, b);
                  index_in = index_inc;
                  if (index_ff == 17'd2) begin
                     total_in = {9'd0, b};
                  end else if (index_ff == 17'd3) begin
                     total_in = {1'b0, b, total_ff[7:0]} + 17'd2;
                  end else if (index_ff == 17'd5) begin
                     flags_in = b;
                  end
               end
            end
            PH_TRAIL: begin
               if (index_ff == 17'd7) begin
                  rcrc_in = {8'h00, b};
               end else begin
                  rcrc_in = {b, rcrc_ff[7:0]};
               end
               index_in = index_inc;
               if (index_inc >= total_ff) begin
                  phase_in = PH_HUNT0;
               end else if (index_inc >= 17'd9) begin
                  phase_in = PH_BODY;
                  bcrc_in  = 16'h0000;
               end
            end
            PH_BODY: begin
               bcrc_in      = sfr_pkg::crc16_update(bcrc_ff, b);
               index_in     = index_inc;
               emit         = 1'b1;
               rsp_in.kind  = sfr_pkg::KIND_BODY;
               rsp_in.value = b;
               if (index_inc >= total_ff) begin
                  rsp_in.last    = 1'b1;
                  rsp_in.body_ok = (bcrc_in == rcrc_ff);
                  phase_in       = PH_HUNT0;
               end
            end
            default: begin
               prev_in  = b;
               phase_in = PH_HUNT1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT0;
         prev_ff  <= 8'h00;
         index_ff <= 17'd0;
         total_ff <= 17'd0;
         flags_ff <= 8'h00;
         hcrc_ff  <= 8'h00;
         bcrc_ff  <= 16'h0000;
         rcrc_ff  <= 16'h0000;
         txseq_ff <= 2'd0;
      end else if (fire) begin
         phase_ff <= phase_in;
         prev_ff  <= prev_in;
         index_ff <= index_in;
         total_ff <= total_in;
         flags_ff <= flags_in;
         hcrc_ff  <= hcrc_in;
         bcrc_ff  <= bcrc_in;
         rcrc_ff  <= rcrc_in;
         txseq_ff <= txseq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= fire && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   a_last_is_body: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last) |-> (rsp_ff.kind == sfr_pkg::KIND_BODY))
      else $error("last flag on a non-body result");

   a_ok_needs_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.body_ok) |-> rsp_ff.last)
      else $error("body_ok without last");

   a_rehunt_after_last: assert property (@(posedge clock) disable iff (reset)
      (fire && emit && rsp_in.last) |=> (phase_ff == PH_HUNT0))
      else $error("parser did not return to hunting after last body byte");

   a_header_index: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEADER) |-> (index_ff >= 17'd2 && index_ff <= 17'd6))
      else $error("header byte index out of range");

endmodule

`default_nettype wire

@@ rtl/serial_frame_receiver_crc_top.sv @@
// Serial frame receiver with header CRC8 and body CRC-16/KERMIT.
// Holds the configuration registers; depends on sfr_pkg, sfr_in_reg, sfr_parser.
//
// Usage:
//   Request channel (req_*): one received byte (req_mode 0) or a clear of the
//   transmit sequence (req_mode 1) per accepted request.
//   Response channel (rsp_*): at most one result per request: body byte,
//   ack received, ack to send or header CRC error.
//   CSR port: index 0 writes the 16-bit signature, index 1 the ack flag mask.
//   Write only while no request is in flight.
// Path: the input register takes a request at the edge that accepts it; the parser
//   then writes its result into the result register once it may advance, so a
//   stalled response can delay the result before it appears on rsp_valid.
// Throughput: one request per cycle while rsp_stall is low, set by the combinational
//   parser update between the two registers.
// Reset: synchronous; empties both registers, returns the parser to hunting
//   and restores the signature 0xDEAD and ack mask 0x01.
// Stall: a stalled response holds; the held request stalls behind it and
//   req_stall rises, so nothing is dropped.
`default_nettype none

module serial_frame_receiver_crc_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_mode,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_value,
   output logic             rsp_last,
   output logic             rsp_body_ok,
   input  wire logic        csr_write_enable,
   input  wire logic [0:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);

   sfr_pkg::cfg_type    cfg_ff;
   sfr_pkg::item_type   item;
   sfr_pkg::result_type rsp;
   logic                item_valid;
   logic                advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.signature <= sfr_pkg::SIGNATURE_RESET;
         cfg_ff.ack_mask  <= sfr_pkg::ACK_MASK_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            sfr_pkg::CSR_SIGNATURE: cfg_ff.signature <= csr_write_data;
            sfr_pkg::CSR_ACK_MASK:  cfg_ff.ack_mask  <= csr_write_data[7:0];
            default: begin
            end
         endcase
      end
   end

   sfr_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_mode    (req_mode),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .item_valid  (item_valid),
      .item        (item)
   );

   sfr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   assign rsp_kind    = rsp.kind;
   assign rsp_value   = rsp.value;
   assign rsp_last    = rsp.last;
   assign rsp_body_ok = rsp.body_ok;

endmodule

`default_nettype wire

@@ sim/tb_serial_frame_receiver_crc_top.sv @@
// Self-checking testbench for serial_frame_receiver_crc_top: table-driven frames, then
// random frames, noise and clears under several signature and ack-mask settings.
// Depends on rtl/sfr_pkg.sv and the RTL below serial_frame_receiver_crc_top.
`timescale 1ns / 1ps

module tb_serial_frame_receiver_crc_top;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASE_REQS  = 90;

   typedef enum logic [2:0] {
      SEEK_EMPTY, SEEK_HELD, IN_HEADER, IN_TRAILER, IN_BODY
   } rx_phase_type;

   typedef enum logic [1:0] {ROW_BYTE, ROW_CLEAR, ROW_HDR_CRC, ROW_HDR_BAD} row_op_type;
   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_FIXED} row_check_type;

   typedef struct packed {
      row_op_type    op;
      logic [7:0]    data;
      row_check_type chk;
      logic [1:0]    kind;
      logic [7:0]    value;
      logic          last;
      logic          ok;
   } stim_row_type;

   // header CRC rows take their byte from the four bytes sent before them
   localparam stim_row_type DIRECTED_ROWS [26] = '{
      '{ROW_CLEAR,   8'hA5, CHK_NONE,  sfr_pkg::KIND_BODY,    8'h00, 1'b0, 1'b0},
      '{ROW_BYTE,    8'h00, CHK_MODEL, sfr_pkg::KIND_BODY,    8'h00, 1'b0, 1'b0},
      '{ROW_BYTE,    8'hDE, CHK_MODEL, sfr_pkg::KIND_BODY,    8'h00, 1'b0, 1'b0},
      '{ROW_BYTE,    8'hAD, CHK_MODEL, sfr_pkg::KIND_BODY,    8'h00, 1'b0, 1'b0},
      '{ROW_BYTE,    8'h00, CHK_MODEL, sfr_pkg::KIND_BODY,    8'h00, 1'b0, 1'b0},
      '{ROW_BYTE,    8'h00, CHK_MODEL, sfr_pkg::KIND_BODY,    8'h00, 1'b0, 1'b0},
      '{ROW_BYTE,    8'hFF, CHK_MODEL, sfr_pkg::KIND_BODY,    8'h00, 1'b0, 1'b0},
      '{ROW_BYTE,    8'h0C, CHK_MODEL, sfr_pkg::KIND_BODY,    8'h00, 1'b0, 1'b0},
      '{ROW_HDR_CRC, 8'h00, CHK_FIXED, sfr_pkg::KIND_ACK_TX,  8'h03, 1'b0, 1'b0},
      '{ROW_BYTE,    8'hDE, CHK_MODEL, sfr_pkg::KIND_BODY,    8'h00, 1'b0, 1'b0},
      '{ROW_BYTE,    8'hAD, CHK_MODEL, sfr_pkg::KIND_BODY,    8'h00, 1'b0, 1'b0},
      '{ROW_BYTE,    8'h08, CHK_MODEL, sfr_pkg::KIND_BODY,    8'h00, 1'b0, 1'b0},
      '{ROW_BYTE,    8'h00, CHK_MODEL, sfr_pkg::KIND_BODY,    8'h00, 1'b0, 1'b0},
      '{ROW_BYTE,    8'h00, CHK_MODEL, sfr_pkg::KIND_BODY,    8'h00, 1'b0, 1'b0},
      '{ROW_BYTE,    8'h01, CHK_MODEL, sfr_pkg::KIND_BODY,    8'h00, 1'b0, 1'b0},
      '{ROW_HDR_CRC, 8'h00, CHK_FIXED, sfr_pkg::KIND_ACK_RX,  8'h00, 1'b0, 1'b0},
      '{ROW_BYTE,    8'h00, CHK_NONE,  sfr_pkg::KIND_BODY,    8'h00, 1'b0, 1'b0},
      '{ROW_BYTE,    8'h00, CHK_NONE,  sfr_pkg::KIND_BODY,    8'h00, 1'b0, 1'b0},
      '{ROW_BYTE,    8'h00, CHK_FIXED, sfr_pkg::KIND_BODY,    8'h00, 1'b1, 1'b1},
      '{ROW_BYTE,    8'hDE, CHK_MODEL, sfr_pkg::KIND_BODY,    8'h00, 1'b0, 1'b0},
      '{ROW_BYTE,    8'hAD, CHK_MODEL, sfr_pkg::KIND_BODY,    8'h00, 1'b0, 1'b0},
      '{ROW_BYTE,    8'hFF, CHK_MODEL, sfr_pkg::KIND_BODY,    8'h00, 1'b0, 1'b0},
      '{ROW_BYTE,    8'hFF, CHK_MODEL, sfr_pkg::KIND_BODY,    8'h00, 1'b0, 1'b0},
      '{ROW_BYTE,    8'h80, CHK_MODEL, sfr_pkg::KIND_BODY,    8'h00, 1'b0, 1'b0},
      '{ROW_BYTE,    8'hF1, CHK_MODEL, sfr_pkg::KIND_BODY,    8'h00, 1'b0, 1'b0},
      '{ROW_HDR_BAD, 8'h00, CHK_FIXED, sfr_pkg::KIND_HDR_ERR, 8'h00, 1'b0, 1'b0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_mode = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_value;
   logic        rsp_last;
   logic        rsp_body_ok;
   logic        csr_write_enable = 1'b0;
   logic [0:0]  csr_index = sfr_pkg::CSR_SIGNATURE;
   logic [15:0] csr_write_data = 16'h0000;

   // expectation pinned to the request on the bus
   row_check_type       pin_check = CHK_MODEL;
   sfr_pkg::result_type pin_result = '0;

   bit          gaps_on = 1'b1;
   int          cycle_count = 0;
   int          failures = 0;
   int          req_count = 0;
   logic [15:0] drv_signature = sfr_pkg::SIGNATURE_RESET;

   sfr_pkg::result_type due_results [$];

   // deframer state as the block should hold it
   rx_phase_type rx_phase;
   logic [7:0]  held_byte;
   logic [16:0] frame_pos;
   logic [16:0] frame_total;
   logic [7:0]  frame_flags;
   logic [7:0]  hdr_crc;
   logic [15:0] body_crc;
   logic [15:0] sent_body_crc;
   logic [1:0]  ack_seq;
   logic [15:0] cfg_signature;
   logic [7:0]  cfg_ack_mask;

   serial_frame_receiver_crc_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_value        (rsp_value),
      .rsp_last         (rsp_last),
      .rsp_body_ok      (rsp_body_ok),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   function automatic logic [7:0] hdr_crc_next(input logic [7:0] c, input logic [7:0] b);
      logic [7:0] x;
      x = c ^ b;
      repeat (8) x = {1'b0, x[7:1]} ^ (x[0] ? 8'hB2 : 8'h00);
      return x ^ 8'hEA;
   endfunction

   function automatic logic [15:0] body_crc_next(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] x;
      x = c ^ {8'h00, b};
      repeat (8) x = {1'b0, x[15:1]} ^ (x[0] ? 16'h8408 : 16'h0000);
      return x;
   endfunction

   // advance the deframer by one request; fired says whether a result comes out
   task automatic deframe_step(input logic m, input logic [7:0] b,
                               output bit fired, output sfr_pkg::result_type r);
      logic [7:0] f;
      fired = 1'b0;
      r = '0;
      if (m) begin
         ack_seq = 2'd0;
         return;
      end
      case (rx_phase)
         SEEK_HELD: begin
            if ({held_byte, b} == cfg_signature) begin
               rx_phase = IN_HEADER;
               frame_pos = 17'd2;
               hdr_crc = 8'h00;
               frame_total = 17'd0;
            end else begin
               held_byte = b;
            end
         end
         IN_HEADER: begin
            if (frame_pos == 17'd6) begin
               f = frame_flags;
               frame_pos = 17'd7;
               if (frame_total > 17'd7) rx_phase = IN_TRAILER;
               else rx_phase = SEEK_EMPTY;
               fired = 1'b1;
               if (b != hdr_crc) begin
                  rx_phase = SEEK_EMPTY;
                  r.kind = sfr_pkg::KIND_HDR_ERR;
               end else if ((f & cfg_ack_mask) != 8'h00) begin
                  if (f[5:4] == ack_seq) begin
                     ack_seq = ack_seq + 2'd1;
                     r.kind = sfr_pkg::KIND_ACK_RX;
                     r.value = {6'd0, f[5:4]};
                  end else begin
                     fired = 1'b0;
                  end
               end else begin
                  r.kind = sfr_pkg::KIND_ACK_TX;
                  r.value = {6'd0, f[3:2]};
               end
            end else begin
               hdr_crc = hdr_crc_next(hdr_crc, b);
               case (frame_pos)
                  17'd2: frame_total = {9'd0, b};
                  17'd3: frame_total = {1'b0, b, frame_total[7:0]} + 17'd2;
                  17'd5: frame_flags = b;
                  default: ;
               endcase
               frame_pos = frame_pos + 17'd1;
            end
         end
         IN_TRAILER: begin
            if (frame_pos == 17'd7) sent_body_crc = {8'h00, b};
            else sent_body_crc = {b, sent_body_crc[7:0]};
            frame_pos = frame_pos + 17'd1;
            if (frame_pos >= frame_total) begin
               rx_phase = SEEK_EMPTY;
            end else if (frame_pos >= 17'd9) begin
               rx_phase = IN_BODY;
               body_crc = 16'h0000;
            end
         end
         IN_BODY: begin
            body_crc = body_crc_next(body_crc, b);
            frame_pos = frame_pos + 17'd1;
            fired = 1'b1;
            r.kind = sfr_pkg::KIND_BODY;
            r.value = b;
            if (frame_pos >= frame_total) begin
               r.last = 1'b1;
               r.body_ok = (body_crc == sent_body_crc);
               rx_phase = SEEK_EMPTY;
            end
         end
         default: begin
            held_byte = b;
            rx_phase = SEEK_HELD;
         end
      endcase
   endtask

   task automatic note_mismatch(input string field, input int want, input int got);
      failures++;
      if (failures <= 200) $error("%s: expected %0d, got %0d", field, want, got);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= gaps_on && ($urandom_range(99) < 33);
   end

   always @(posedge clock) begin : scoreboard
      bit                  fired;
      sfr_pkg::result_type predicted;
      sfr_pkg::result_type want;
      if (reset) begin
         rx_phase = SEEK_EMPTY;
         held_byte = 8'h00;
         frame_pos = 17'd0;
         frame_total = 17'd0;
         frame_flags = 8'h00;
         hdr_crc = 8'h00;
         body_crc = 16'h0000;
         sent_body_crc = 16'h0000;
         ack_seq = 2'd0;
         cfg_signature = sfr_pkg::SIGNATURE_RESET;
         cfg_ack_mask = sfr_pkg::ACK_MASK_RESET;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == sfr_pkg::CSR_SIGNATURE) cfg_signature = csr_write_data;
            else cfg_ack_mask = csr_write_data[7:0];
         end
         if (req_valid && !req_stall) begin
            deframe_step(req_mode, req_rx_byte, fired, predicted);
            if (pin_check == CHK_FIXED) due_results.push_back(pin_result);
            else if (pin_check == CHK_MODEL && fired) due_results.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               failures++;
               if (failures <= 200)
                  $error("unexpected response: kind %0d value %0d", rsp_kind, rsp_value);
            end else begin
               want = due_results.pop_front();
               if (rsp_kind !== want.kind) note_mismatch("kind", want.kind, rsp_kind);
               if (rsp_value !== want.value) note_mismatch("value", want.value, rsp_value);
               if (rsp_last !== want.last) note_mismatch("last", want.last, rsp_last);
               if (rsp_body_ok !== want.body_ok)
                  note_mismatch("body_ok", want.body_ok, rsp_body_ok);
            end
         end
      end
   end

   // hold the request until accepted; gaps go in front of it
   task automatic send_req(input logic m, input logic [7:0] b, input row_check_type chk,
                           input sfr_pkg::result_type fixed);
      while (gaps_on && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_rx_byte <= b;
      pin_check <= chk;
      pin_result <= fixed;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req_count++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_req(1'b0, b, CHK_MODEL, '0);
   endtask

   // drop valid and wait for every result, plus the pipeline depth for silent requests
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // the caller drops the write enable after its last write
   task automatic write_reg(input logic [0:0] idx, input logic [15:0] wdata);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= wdata;
      @(posedge clock);
   endtask

   task automatic send_frame(input logic [15:0] len, input logic [7:0] ftype,
                             input logic [7:0] flags, input bit bad_hdr, input bit bad_body);
      logic [16:0] total;
      logic [7:0]  c8;
      logic [15:0] c16;
      logic [7:0]  body [$];
      int          n;
      total = {1'b0, len} + 17'd2;
      c8 = hdr_crc_next(8'h00, len[7:0]);
      c8 = hdr_crc_next(c8, len[15:8]);
      c8 = hdr_crc_next(c8, ftype);
      c8 = hdr_crc_next(c8, flags);
      send_byte(drv_signature[15:8]);
      send_byte(drv_signature[7:0]);
      send_byte(len[7:0]);
      send_byte(len[15:8]);
      send_byte(ftype);
      send_byte(flags);
      send_byte(bad_hdr ? c8 ^ 8'($urandom_range(1, 255)) : c8);
      if (bad_hdr || total <= 17'd7) return;
      n = (total > 17'd9) ? int'(total) - 9 : 0;
      c16 = 16'h0000;
      for (int k = 0; k < n; k++) begin
         body.push_back(8'($urandom));
         c16 = body_crc_next(c16, body[k]);
      end
      if (bad_body) c16 = c16 ^ 16'($urandom_range(1, 65535));
      send_byte(c16[7:0]);
      if (total > 17'd8) send_byte(c16[15:8]);
      foreach (body[k]) send_byte(body[k]);
   endtask

   initial begin : stimulus
      int                  start;
      int                  pick;
      int                  n;
      logic [7:0]          hist [4];
      logic [7:0]          b;
      logic [7:0]          hc;
      logic [7:0]          flags;
      logic [15:0]         len;
      stim_row_type        row;
      sfr_pkg::result_type fixed_res;
      logic [15:0]         sig_set [5];
      logic [7:0]          mask_set [5];

      hist = '{8'h00, 8'h00, 8'h00, 8'h00};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 26; i++) begin
         row = DIRECTED_ROWS[i];
         fixed_res.kind = row.kind;
         fixed_res.value = row.value;
         fixed_res.last = row.last;
         fixed_res.body_ok = row.ok;
         hc = 8'h00;
         for (int k = 0; k < 4; k++) hc = hdr_crc_next(hc, hist[k]);
         case (row.op)
            ROW_HDR_CRC: b = hc;
            ROW_HDR_BAD: b = hc ^ 8'h5A;
            default:     b = row.data;
         endcase
         if (row.op == ROW_CLEAR) begin
            send_req(1'b1, b, row.chk, fixed_res);
         end else begin
            send_req(1'b0, b, row.chk, fixed_res);
            hist = '{hist[1], hist[2], hist[3], b};
         end
      end

      // long frame with no gaps on either side
      gaps_on = 1'b0;
      send_frame(16'd60, 8'h5C, 8'h00, 1'b0, 1'b0);
      gaps_on = 1'b1;

      sig_set[0] = 16'h0000;                 mask_set[0] = 8'hFF;
      sig_set[1] = 16'hFFFF;                 mask_set[1] = 8'h00;
      sig_set[2] = 16'($urandom);            mask_set[2] = 8'h01 << $urandom_range(7);
      sig_set[3] = 16'($urandom);            mask_set[3] = 8'($urandom);
      sig_set[4] = sfr_pkg::SIGNATURE_RESET; mask_set[4] = sfr_pkg::ACK_MASK_RESET;

      for (int p = 0; p < 5; p++) begin
         wait_idle();
         write_reg(sfr_pkg::CSR_SIGNATURE, sig_set[p]);
         write_reg(sfr_pkg::CSR_ACK_MASK, {8'h00, mask_set[p]});
         csr_write_enable <= 1'b0;
         drv_signature = sig_set[p];
         start = req_count;
         while (req_count - start < PHASE_REQS) begin
            pick = $urandom_range(99);
            if (pick < 66) begin
               n = $urandom_range(99);
               if (n < 35) len = 16'($urandom_range(0, 7));
               else if (n < 90) len = 16'($urandom_range(8, 30));
               else if (n < 97) len = 16'($urandom_range(31, 120));
               else len = 16'($urandom_range(250, 300));
               flags = 8'($urandom);
               // favor acks that carry the expected id
               if ($urandom_range(1) == 1) flags[5:4] = ack_seq;
               send_frame(len, 8'($urandom), flags, $urandom_range(99) < 10,
                          $urandom_range(99) < 15);
            end else if (pick < 74) begin
               send_req(1'b1, 8'($urandom), CHK_MODEL, '0);
            end else if (pick < 86) begin
               repeat ($urandom_range(1, 4)) begin
                  b = ($urandom_range(3) == 0) ? drv_signature[15:8] : 8'($urandom);
                  send_byte(b);
               end
            end else if (pick < 96) begin
               // short or corrupt header: signature followed by one to five stray bytes
               send_byte(drv_signature[15:8]);
               send_byte(drv_signature[7:0]);
               repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
            end else begin
               wait_idle();
            end
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (failures == 0 && due_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/sfr_pkg.sv
rtl/sfr_in_reg.sv
rtl/sfr_parser.sv
rtl/serial_frame_receiver_crc_top.sv
sim/tb_serial_frame_receiver_crc_top.sv
